>>> rtl/uart_frame_receiver_checksum_defines.svh
// Assertion macros for the frame receiver checker.
// No dependencies; taken in by the checker file only.
`ifndef UART_FRAME_RECEIVER_CHECKSUM_DEFINES_SVH
`define UART_FRAME_RECEIVER_CHECKSUM_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define UFRC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: %m");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define UFRC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

>>> rtl/ufrc_pkg.sv
// Shared types and constants for the frame receiver.
// No dependencies; used by the top level and its checker.
`default_nettype none

package ufrc_pkg;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_GOOD      = 3'd1,
    ST_SHORT     = 3'd2,
    ST_BAD_TYPE  = 3'd3,
    ST_BAD_CSUM  = 3'd4,
    ST_OVERFLOW  = 3'd5
  } frame_status_t;

  // Frame layout, as 9-bit values so they compare against 3 + length
  localparam logic [8:0] FRAME_OVERHEAD = 9'd3;
  localparam logic [8:0] MIN_FRAME_LEN  = 9'd4;
  localparam logic [8:0] LEN_POS        = 9'd2;
  localparam logic [8:0] TYPE_POS       = 9'd3;

  // Config register indexes
  localparam logic CFG_START_BYTE = 1'b0;
  localparam logic CFG_EXP_TYPE   = 1'b1;

  // Result tdata layout
  localparam int OUT_TDATA_W   = 56;
  localparam int OD_ACTIVE     = 0;
  localparam int OD_POS_LO     = 1;
  localparam int OD_POS_HI     = 6;
  localparam int OD_STATUS_LO  = 7;
  localparam int OD_STATUS_HI  = 9;
  localparam int OD_FLEN_LO    = 10;
  localparam int OD_FLEN_HI    = 16;
  localparam int OD_CSUM_LO    = 17;
  localparam int OD_CSUM_HI    = 32;
  localparam int OD_FMT_LO     = 33;
  localparam int OD_FMT_HI     = 48;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

endpackage

`default_nettype wire

>>> rtl/uart_frame_receiver_checksum.sv
// Channel  | Signals                                  | Role
// ---------+------------------------------------------+-------------------------------
// in       | in_tvalid/in_tready/in_tdata             | one received byte per transaction
// out      | out_tvalid/out_tready/out_tdata/out_tlast| one result per input byte
// cfg      | cfg_we/cfg_addr/cfg_wdata                | start byte, expected type
//
// One byte per cycle while out_tready allows it: frame state updates in the accept
// cycle, and the result sits in a single output register from the next cycle.
// in_tready follows out_tready when the output register holds a result.
// rst_n (sync, active low) clears frame state, error counters and output valid;
// config registers return to start byte 0x7E and expected type 0x31.
// Depends on ufrc_pkg.
`default_nettype none

module uart_frame_receiver_checksum
  import ufrc_pkg::*;
#(
  parameter int MAX_FRAME = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [7:0]             in_tdata,   // [7:0] rx_byte
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [0] frame_active, [6:1] byte_position, [9:7] status, [16:10] frame_length,
  // [32:17] checksum_error_count, [48:33] format_error_count, [55:49] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tlast,  // frame_end
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_addr,
  input  wire logic [7:0]             cfg_wdata
);

  localparam int CW = $clog2(MAX_FRAME + 1);
  localparam logic [8:0] MAX_FRAME_9 = 9'(MAX_FRAME);

  logic [7:0]    start_byte_r, exp_type_r;
  logic          in_frame_r, in_frame_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [7:0]    type_r, type_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [15:0]   csum_err_r, csum_err_nxt;
  logic [15:0]   fmt_err_r, fmt_err_nxt;

  logic                    out_valid_r;
  logic [OUT_TDATA_W-1:0]  out_data_r, out_data_nxt;
  logic                    out_last_r, out_last_nxt;

  logic          in_acc;
  logic [7:0]    b;
  logic [8:0]    idx9, total9, cnt_inc9;
  logic [7:0]    len_eff, type_eff;
  logic          active;
  logic [5:0]    pos;
  frame_status_t status;
  logic [6:0]    flen;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign b         = in_tdata;

  assign idx9     = 9'(cnt_r);
  assign cnt_inc9 = idx9 + 9'd1;
  assign len_eff  = (idx9 == LEN_POS)  ? b : len_r;
  assign type_eff = (idx9 == TYPE_POS) ? b : type_r;
  assign total9   = FRAME_OVERHEAD + 9'(len_eff);

  always_comb begin
    in_frame_nxt = in_frame_r;
    cnt_nxt      = cnt_r;
    len_nxt      = len_r;
    type_nxt     = type_r;
    sum_nxt      = sum_r;
    csum_err_nxt = csum_err_r;
    fmt_err_nxt  = fmt_err_r;
    active       = 1'b0;
    pos          = 6'd0;
    out_last_nxt = 1'b0;
    status       = ST_NONE;
    flen         = 7'd0;

    if (!in_frame_r) begin
      if (b == start_byte_r) begin
        in_frame_nxt = 1'b1;
        cnt_nxt      = CW'(1);
        len_nxt      = 8'd0;
        type_nxt     = 8'd0;
        sum_nxt      = 8'd0;
        active       = 1'b1;
      end
    end else if (idx9 >= MAX_FRAME_9) begin
      // store full: drop this byte and abort the frame
      out_last_nxt = 1'b1;
      status       = ST_OVERFLOW;
      flen         = idx9[6:0];
      in_frame_nxt = 1'b0;
      cnt_nxt      = '0;
    end else begin
      active   = 1'b1;
      pos      = idx9[5:0];
      cnt_nxt  = cnt_inc9[CW-1:0];
      len_nxt  = len_eff;
      type_nxt = type_eff;
      if (idx9 >= LEN_POS) begin
        if (cnt_inc9 >= total9) begin
          out_last_nxt = 1'b1;
          flen         = total9[6:0];
          if (total9 < MIN_FRAME_LEN) begin
            status      = ST_SHORT;
            fmt_err_nxt = (fmt_err_r == CNT_MAX) ? fmt_err_r : fmt_err_r + 16'd1;
          end else if (type_eff != exp_type_r) begin
            status      = ST_BAD_TYPE;
            fmt_err_nxt = (fmt_err_r == CNT_MAX) ? fmt_err_r : fmt_err_r + 16'd1;
          end else if (b != sum_r) begin
            status       = ST_BAD_CSUM;
            csum_err_nxt = (csum_err_r == CNT_MAX) ? csum_err_r : csum_err_r + 16'd1;
          end else begin
            status = ST_GOOD;
          end
          in_frame_nxt = 1'b0;
          cnt_nxt      = '0;
        end else begin
          sum_nxt = sum_r + b;
        end
      end
    end

    out_data_nxt = '0;
    out_data_nxt[OD_ACTIVE]                 = active;
    out_data_nxt[OD_POS_HI:OD_POS_LO]       = pos;
    out_data_nxt[OD_STATUS_HI:OD_STATUS_LO] = status;
    out_data_nxt[OD_FLEN_HI:OD_FLEN_LO]     = flen;
    out_data_nxt[OD_CSUM_HI:OD_CSUM_LO]     = csum_err_nxt;
    out_data_nxt[OD_FMT_HI:OD_FMT_LO]       = fmt_err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= 8'd126;
      exp_type_r   <= 8'd49;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_START_BYTE: start_byte_r <= cfg_wdata;
        CFG_EXP_TYPE:   exp_type_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      cnt_r      <= '0;
      len_r      <= 8'd0;
      type_r     <= 8'd0;
      sum_r      <= 8'd0;
      csum_err_r <= 16'd0;
      fmt_err_r  <= 16'd0;
    end else if (in_acc) begin
      in_frame_r <= in_frame_nxt;
      cnt_r      <= cnt_nxt;
      len_r      <= len_nxt;
      type_r     <= type_nxt;
      sum_r      <= sum_nxt;
      csum_err_r <= csum_err_nxt;
      fmt_err_r  <= fmt_err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

>>> rtl/ufrc_checker.sv
// Port-level checker for the frame receiver, bound to the top level.
// Depends on ufrc_pkg and uart_frame_receiver_checksum_defines.svh.
`default_nettype none
`include "uart_frame_receiver_checksum_defines.svh"

module ufrc_checker
  import ufrc_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tlast
);

  // a stalled result transaction keeps its payload
  `UFRC_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // a frame end always carries a verdict, anything else carries none
  `UFRC_ASSERT_IMP(a_end_status, out_tvalid && out_tlast, out_tdata[OD_STATUS_HI:OD_STATUS_LO] != ST_NONE)
  `UFRC_ASSERT_IMP(a_mid_quiet, out_tvalid && !out_tlast, out_tdata[OD_STATUS_HI:OD_STATUS_LO] == ST_NONE && out_tdata[OD_FLEN_HI:OD_FLEN_LO] == 7'd0)

  // overflow drops the byte
  `UFRC_ASSERT_IMP(a_ovf_drop, out_tvalid && out_tdata[OD_STATUS_HI:OD_STATUS_LO] == ST_OVERFLOW, !out_tdata[OD_ACTIVE] && out_tdata[OD_POS_HI:OD_POS_LO] == 6'd0)

endmodule

bind uart_frame_receiver_checksum ufrc_checker u_ufrc_checker (.*);

`default_nettype wire
